/* rtl/lavt_pkg.sv */
// shared constants, types and rounding, clamping and saturating helpers for the look-at view transform
`timescale 1ns / 1ps

package lavt_pkg;

    // register stages inside one vector normalizer
    localparam int NORM_LAT   = 70;
    // steps of the square root and of the divider
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    // scaled magnitudes have their leading one at this bit
    localparam logic [5:0] MAG_TOP = 6'd30;

    localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
    localparam logic signed [63:0] ONE_Q30_W = 64'sh0000_0000_4000_0000;
    localparam logic signed [63:0] MAX_I32_W = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] MIN_I32_W = -64'sh0000_0000_8000_0000;

    // row codes of the result channel
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    // mode codes
    localparam logic ACT_TO_VIEW  = 1'b0;
    localparam logic ACT_TO_WORLD = 1'b1;

    // status that leaves a normalizer
    typedef struct packed {
        logic vld;
        logic zero;
    } norm_stat_t;

    // side data that travels through a normalizer
    typedef struct packed {
        logic       vld;
        logic       zero;
        logic [2:0] neg;
    } nside_t;

    // divide by 2^30, rounding half away from zero
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? $unsigned(-v) : $unsigned(v);
        r   = (mag + (64'd1 << 29)) >> 30;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    // clamp to +/- one in Q2.30
    function automatic logic signed [31:0] clamp_one(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30_W) begin
            r = ONE_Q30;
        end else if (v < -ONE_Q30_W) begin
            r = -ONE_Q30;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // saturate to a signed 32 bit value
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > MAX_I32_W) begin
            r = MAX_I32_W[31:0];
        end else if (v < MIN_I32_W) begin
            r = MIN_I32_W[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/lavt_pts_if.sv */
// input channel: eye, focus and up vector of one transaction
`timescale 1ns / 1ps

interface lavt_pts_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] focus_x;
    logic signed [31:0] focus_y;
    logic signed [31:0] focus_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;

    modport source (
        output valid, action, eye_x, eye_y, eye_z, focus_x, focus_y, focus_z,
               up_x, up_y, up_z,
        input  ready
    );
    modport sink (
        input  valid, action, eye_x, eye_y, eye_z, focus_x, focus_y, focus_z,
               up_x, up_y, up_z,
        output ready
    );
endinterface

/* rtl/lavt_rows_if.sv */
// result channel: one matrix row per transaction
`timescale 1ns / 1ps

interface lavt_rows_if;
    logic               valid;
    logic               ready;
    logic [1:0]         row_index;
    logic signed [31:0] row_m0;
    logic signed [31:0] row_m1;
    logic signed [31:0] row_m2;
    logic signed [31:0] row_trans;
    logic               degenerate;
    logic               last_row;

    modport source (
        output valid, row_index, row_m0, row_m1, row_m2, row_trans, degenerate,
               last_row,
        input  ready
    );
    modport sink (
        input  valid, row_index, row_m0, row_m1, row_m2, row_trans, degenerate,
               last_row,
        output ready
    );
endinterface

/* rtl/lavt_norm.sv */
// pipelined 3-vector normalizer: scale, square sum, square root, divide
`timescale 1ns / 1ps

module lavt_norm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 vin,
    input  logic signed [63:0]   v [3],
    output lavt_pkg::norm_stat_t stat,
    output logic signed [31:0]   q [3]
);
    import lavt_pkg::*;

    logic [63:0] negv [3];
    logic [62:0] a1_next [3];
    logic [62:0] a1_reg [3];
    logic [2:0]  neg1_reg;
    logic        vld1_reg;

    logic [62:0] or2;
    logic [5:0]  p2_next;
    logic [5:0]  p2_reg;
    logic [62:0] a2_reg [3];
    nside_t      side2_reg;

    logic [30:0] m3_next [3];
    logic [30:0] m3_reg [3];
    nside_t      side3_reg;

    logic [61:0] sq4_reg [3];
    logic [30:0] m4_reg [3];
    nside_t      side4_reg;

    logic [63:0] sn_reg [SQRT_STEPS+1];
    logic [63:0] sr_reg [SQRT_STEPS+1];
    logic [30:0] sm_reg [SQRT_STEPS+1][3];
    nside_t      sside_reg [SQRT_STEPS+1];

    logic [32:0] rr_reg;
    logic [30:0] rm_reg [3];
    nside_t      rside_reg;
    logic [61:0] num [3];

    logic [32:0] dn_reg [DIV_STEPS];
    logic [32:0] drem_reg [DIV_STEPS][3];
    logic [30:0] dlo_reg [DIV_STEPS][3];
    logic [30:0] dq_reg [DIV_STEPS][3];
    nside_t      dside_reg [DIV_STEPS];

    logic signed [31:0] q_next [3];
    logic signed [31:0] q_reg [3];
    norm_stat_t         stat_reg;

    // magnitudes and signs
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            negv[i]    = $unsigned(-v[i]);
            a1_next[i] = v[i][63] ? negv[i][62:0] : v[i][62:0];
        end
    end

    // leading one of the largest magnitude
    always_comb
    begin
        or2     = a1_reg[0] | a1_reg[1] | a1_reg[2];
        p2_next = '0;
        for (int k = 0; k < 63; k++)
        begin
            if (or2[k])
            begin
                p2_next = 6'(k);
            end
        end
    end

    // scale so that the leading one sits at bit 30
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (p2_reg >= MAG_TOP)
            begin
                m3_next[i] = 31'(a2_reg[i] >> (p2_reg - MAG_TOP));
            end
            else
            begin
                m3_next[i] = 31'(a2_reg[i] << (MAG_TOP - p2_reg));
            end
        end
    end

    // front stages: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg     <= 1'b0;
            side2_reg    <= '0;
            side3_reg    <= '0;
            side4_reg    <= '0;
            sside_reg[0] <= '0;
        end
        else if (adv)
        begin
            vld1_reg       <= vin;
            side2_reg.vld  <= vld1_reg;
            side2_reg.zero <= (or2 == '0);
            side2_reg.neg  <= neg1_reg;
            side3_reg      <= side2_reg;
            side4_reg      <= side3_reg;
            sside_reg[0]   <= side4_reg;
        end
    end

    // front stages: data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i]    <= a1_next[i];
                neg1_reg[i]  <= v[i][63];
                a2_reg[i]    <= a1_reg[i];
                m3_reg[i]    <= m3_next[i];
                sq4_reg[i]   <= {31'd0, m3_reg[i]} * {31'd0, m3_reg[i]};
                m4_reg[i]    <= m3_reg[i];
                sm_reg[0][i] <= m4_reg[i];
            end
            p2_reg    <= p2_next;
            sn_reg[0] <= {2'b00, sq4_reg[0]} + {2'b00, sq4_reg[1]} + {2'b00, sq4_reg[2]};
            sr_reg[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        logic [64:0] trial;

        always_comb
        begin
            trial = {1'b0, sr_reg[k]} + {1'b0, BITV};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if ({1'b0, sn_reg[k]} >= trial)
                begin
                    sn_reg[k+1] <= sn_reg[k] - trial[63:0];
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + BITV;
                end
                else
                begin
                    sn_reg[k+1] <= sn_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
                sm_reg[k+1] <= sm_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sside_reg[k+1] <= '0;
            end
            else if (adv)
            begin
                sside_reg[k+1] <= sside_reg[k];
            end
        end
    end

    // round the root to nearest
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rr_reg <= sr_reg[SQRT_STEPS][32:0]
                      + 33'(sn_reg[SQRT_STEPS] > sr_reg[SQRT_STEPS]);
            rm_reg <= sm_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rside_reg <= '0;
        end
        else if (adv)
        begin
            rside_reg <= sside_reg[SQRT_STEPS];
        end
    end

    // dividend with half the divisor added for rounding
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = {1'b0, rm_reg[i], 30'd0} + {30'd0, rr_reg[32:1]};
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [32:0] src_n;
        logic [32:0] src_rem [3];
        logic [30:0] src_lo [3];
        logic [30:0] src_q [3];
        nside_t      src_side;
        logic [33:0] trial [3];
        logic        fits [3];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                src_n    = rr_reg;
                src_side = rside_reg;
                for (int i = 0; i < 3; i++)
                begin
                    src_rem[i] = {2'b00, num[i][61:31]};
                    src_lo[i]  = num[i][30:0];
                    src_q[i]   = '0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                src_n    = dn_reg[k-1];
                src_side = dside_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    src_rem[i] = drem_reg[k-1][i];
                    src_lo[i]  = dlo_reg[k-1][i];
                    src_q[i]   = dq_reg[k-1][i];
                end
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {src_rem[i], src_lo[i][30]};
                fits[i]  = (trial[i] >= {1'b0, src_n});
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dn_reg[k] <= src_n;
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[k][i] <= fits[i] ? 33'(trial[i] - {1'b0, src_n})
                                              : trial[i][32:0];
                    dlo_reg[k][i]  <= {src_lo[i][29:0], 1'b0};
                    dq_reg[k][i]   <= {src_q[i][29:0], fits[i]};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dside_reg[k] <= '0;
            end
            else if (adv)
            begin
                dside_reg[k] <= src_side;
            end
        end
    end

    // sign back and clamp to one
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_next[i] = clamp_one(dside_reg[DIV_STEPS-1].neg[i]
                                  ? -$signed({33'd0, dq_reg[DIV_STEPS-1][i]})
                                  : $signed({33'd0, dq_reg[DIV_STEPS-1][i]}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= q_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '0;
        end
        else if (adv)
        begin
            stat_reg.vld  <= dside_reg[DIV_STEPS-1].vld;
            stat_reg.zero <= dside_reg[DIV_STEPS-1].zero;
        end
    end

    assign q    = q_reg;
    assign stat = stat_reg;

endmodule

/* rtl/look_at_view_transform_unit.sv */
// top level of the look-at view transform pipeline
`timescale 1ns / 1ps

// Usage:
//   pts carries one transaction per camera: mode, eye, focus and up vector.
//   rows returns three transactions for it, rows 0, 1 and 2 in that order;
//   last_row marks row 2. Mode 0 gives the world-to-view matrix rows with
//   the rotated, negated eye as translation; mode 1 gives the transposed
//   rotation with the eye as translation.
//   A zero-length view direction or side vector sets degenerate and zeros
//   all matrix and translation fields of the three rows.
// Row 0 passes the input register, the z normalizer, t1, t2, the x
//   normalizer, t3 to t7 and the output register; rows 1 and 2 follow in
//   the next cycles when rows.ready is high. A new input transaction is
//   taken only when the output register is empty or its final row is taken.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// A stall on rows freezes the whole pipeline; pts.ready drops with it and
//   nothing is lost or repeated.
module look_at_view_transform_unit (
    input  logic              clk,
    input  logic              rst_n,
    lavt_pts_if.sink          pts,
    lavt_rows_if.source       rows
);
    import lavt_pkg::*;

    typedef struct packed {
        logic             action;
        logic [2:0][31:0] eye;
        logic [2:0][31:0] up;
    } side1_t;

    typedef struct packed {
        logic             action;
        logic [2:0][31:0] eye;
        logic [2:0][31:0] z;
        logic             zero;
    } side2_t;

    logic adv;

    // stage 0
    logic               t0_vld_reg;
    side1_t             t0_side_reg;
    logic signed [32:0] t0_zr_reg [3];
    logic signed [63:0] n1_v [3];
    side1_t             sd1_reg [NORM_LAT];
    logic signed [31:0] z1 [3];
    norm_stat_t         st1;

    // side vector
    logic               t1_vld_reg;
    side2_t             t1_side_reg;
    logic signed [63:0] t1_p_reg [6];
    logic               t2_vld_reg;
    side2_t             t2_side_reg;
    logic signed [63:0] t2_xr_reg [3];
    side2_t             sd2_reg [NORM_LAT];
    logic signed [31:0] x2 [3];
    norm_stat_t         st2;

    // up vector and matrix
    logic               t3_vld_reg;
    logic               t3_act_reg;
    logic               t3_zero_reg;
    logic signed [31:0] t3_eye_reg [3];
    logic signed [31:0] t3_z_reg [3];
    logic signed [31:0] t3_x_reg [3];
    logic signed [63:0] t3_p_reg [6];
    logic               t4_vld_reg;
    logic               t4_act_reg;
    logic               t4_zero_reg;
    logic signed [31:0] t4_eye_reg [3];
    logic signed [31:0] t4_z_reg [3];
    logic signed [31:0] t4_x_reg [3];
    logic signed [63:0] t4_yr_reg [3];
    logic               t5_vld_reg;
    logic               t5_act_reg;
    logic               t5_zero_reg;
    logic signed [31:0] t5_eye_reg [3];
    logic signed [31:0] t5_z_reg [3];
    logic signed [31:0] t5_x_reg [3];
    logic signed [31:0] t5_y_reg [3];
    logic signed [31:0] m6_next [3][3];
    logic               t6_vld_reg;
    logic               t6_act_reg;
    logic               t6_zero_reg;
    logic signed [31:0] t6_eye_reg [3];
    logic signed [31:0] t6_m_reg [3][3];
    logic signed [63:0] t6_p_reg [3][3];
    logic               t7_vld_reg;
    logic               t7_act_reg;
    logic               t7_zero_reg;
    logic signed [31:0] t7_eye_reg [3];
    logic signed [31:0] t7_m_reg [3][3];
    logic signed [63:0] t7_acc_reg [3];

    // output register
    logic               ser_vld_reg;
    logic [1:0]         row_reg;
    logic               deg_reg;
    logic signed [31:0] om_reg [3][3];
    logic signed [31:0] ot_reg [3];
    logic signed [31:0] tr_next [3];

    // the whole pipeline moves when the output register frees up
    assign adv       = !ser_vld_reg || (rows.ready && row_reg == ROW_LAST);
    assign pts.ready = adv;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_vld_reg <= 1'b0;
            t1_vld_reg <= 1'b0;
            t2_vld_reg <= 1'b0;
            t3_vld_reg <= 1'b0;
            t4_vld_reg <= 1'b0;
            t5_vld_reg <= 1'b0;
            t6_vld_reg <= 1'b0;
            t7_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            t0_vld_reg <= pts.valid;
            t1_vld_reg <= st1.vld;
            t2_vld_reg <= t1_vld_reg;
            t3_vld_reg <= st2.vld;
            t4_vld_reg <= t3_vld_reg;
            t5_vld_reg <= t4_vld_reg;
            t6_vld_reg <= t5_vld_reg;
            t7_vld_reg <= t6_vld_reg;
        end
    end

    // input capture and view direction
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_side_reg.action <= pts.action;
            t0_side_reg.eye    <= {pts.eye_z, pts.eye_y, pts.eye_x};
            t0_side_reg.up     <= {pts.up_z, pts.up_y, pts.up_x};
            t0_zr_reg[0]       <= 33'(pts.eye_x) - 33'(pts.focus_x);
            t0_zr_reg[1]       <= 33'(pts.eye_y) - 33'(pts.focus_y);
            t0_zr_reg[2]       <= 33'(pts.eye_z) - 33'(pts.focus_z);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_v[i] = 64'(t0_zr_reg[i]);
        end
    end

    // z normalizer with its side line
    lavt_norm u_norm_z (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .vin   (t0_vld_reg),
        .v     (n1_v),
        .stat  (st1),
        .q     (z1)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd1_reg[0] <= t0_side_reg;
            for (int k = 1; k < NORM_LAT; k++)
            begin
                sd1_reg[k] <= sd1_reg[k-1];
            end
        end
    end

    // up cross z products, then differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_side_reg.action <= sd1_reg[NORM_LAT-1].action;
            t1_side_reg.eye    <= sd1_reg[NORM_LAT-1].eye;
            t1_side_reg.z      <= {z1[2], z1[1], z1[0]};
            t1_side_reg.zero   <= st1.zero;
            t1_p_reg[0] <= $signed(sd1_reg[NORM_LAT-1].up[1]) * z1[2];
            t1_p_reg[1] <= $signed(sd1_reg[NORM_LAT-1].up[2]) * z1[1];
            t1_p_reg[2] <= $signed(sd1_reg[NORM_LAT-1].up[2]) * z1[0];
            t1_p_reg[3] <= $signed(sd1_reg[NORM_LAT-1].up[0]) * z1[2];
            t1_p_reg[4] <= $signed(sd1_reg[NORM_LAT-1].up[0]) * z1[1];
            t1_p_reg[5] <= $signed(sd1_reg[NORM_LAT-1].up[1]) * z1[0];
            t2_side_reg  <= t1_side_reg;
            t2_xr_reg[0] <= t1_p_reg[0] - t1_p_reg[1];
            t2_xr_reg[1] <= t1_p_reg[2] - t1_p_reg[3];
            t2_xr_reg[2] <= t1_p_reg[4] - t1_p_reg[5];
        end
    end

    // x normalizer with its side line
    lavt_norm u_norm_x (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .vin   (t2_vld_reg),
        .v     (t2_xr_reg),
        .stat  (st2),
        .q     (x2)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd2_reg[0] <= t2_side_reg;
            for (int k = 1; k < NORM_LAT; k++)
            begin
                sd2_reg[k] <= sd2_reg[k-1];
            end
        end
    end

    // z cross x, rounding and clamping of y
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t3_act_reg  <= sd2_reg[NORM_LAT-1].action;
            t3_zero_reg <= sd2_reg[NORM_LAT-1].zero | st2.zero;
            for (int i = 0; i < 3; i++)
            begin
                t3_eye_reg[i] <= $signed(sd2_reg[NORM_LAT-1].eye[i]);
                t3_z_reg[i]   <= $signed(sd2_reg[NORM_LAT-1].z[i]);
            end
            t3_x_reg <= x2;
            t3_p_reg[0] <= $signed(sd2_reg[NORM_LAT-1].z[1]) * x2[2];
            t3_p_reg[1] <= $signed(sd2_reg[NORM_LAT-1].z[2]) * x2[1];
            t3_p_reg[2] <= $signed(sd2_reg[NORM_LAT-1].z[2]) * x2[0];
            t3_p_reg[3] <= $signed(sd2_reg[NORM_LAT-1].z[0]) * x2[2];
            t3_p_reg[4] <= $signed(sd2_reg[NORM_LAT-1].z[0]) * x2[1];
            t3_p_reg[5] <= $signed(sd2_reg[NORM_LAT-1].z[1]) * x2[0];

            t4_act_reg   <= t3_act_reg;
            t4_zero_reg  <= t3_zero_reg;
            t4_eye_reg   <= t3_eye_reg;
            t4_z_reg     <= t3_z_reg;
            t4_x_reg     <= t3_x_reg;
            t4_yr_reg[0] <= t3_p_reg[0] - t3_p_reg[1];
            t4_yr_reg[1] <= t3_p_reg[2] - t3_p_reg[3];
            t4_yr_reg[2] <= t3_p_reg[4] - t3_p_reg[5];

            t5_act_reg  <= t4_act_reg;
            t5_zero_reg <= t4_zero_reg;
            t5_eye_reg  <= t4_eye_reg;
            t5_z_reg    <= t4_z_reg;
            t5_x_reg    <= t4_x_reg;
            for (int i = 0; i < 3; i++)
            begin
                t5_y_reg[i] <= clamp_one(rnd30(t4_yr_reg[i]));
            end
        end
    end

    // matrix layout by mode
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (t5_act_reg == ACT_TO_WORLD)
            begin
                m6_next[j][0] = t5_x_reg[j];
                m6_next[j][1] = t5_y_reg[j];
                m6_next[j][2] = t5_z_reg[j];
            end
            else
            begin
                m6_next[0][j] = t5_x_reg[j];
                m6_next[1][j] = t5_y_reg[j];
                m6_next[2][j] = t5_z_reg[j];
            end
        end
    end

    // row times eye products, then row sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t6_act_reg  <= t5_act_reg;
            t6_zero_reg <= t5_zero_reg;
            t6_eye_reg  <= t5_eye_reg;
            t6_m_reg    <= m6_next;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    t6_p_reg[i][j] <= m6_next[i][j] * t5_eye_reg[j];
                end
            end

            t7_act_reg  <= t6_act_reg;
            t7_zero_reg <= t6_zero_reg;
            t7_eye_reg  <= t6_eye_reg;
            t7_m_reg    <= t6_m_reg;
            for (int i = 0; i < 3; i++)
            begin
                t7_acc_reg[i] <= t6_p_reg[i][0] + t6_p_reg[i][1] + t6_p_reg[i][2];
            end
        end
    end

    // translation per row
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (t7_act_reg == ACT_TO_VIEW)
            begin
                tr_next[i] = sat32(rnd30(-t7_acc_reg[i]));
            end
            else
            begin
                tr_next[i] = t7_eye_reg[i];
            end
        end
    end

    // output register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_vld_reg <= 1'b0;
            row_reg     <= ROW_FIRST;
        end
        else if (adv)
        begin
            ser_vld_reg <= t7_vld_reg;
            row_reg     <= ROW_FIRST;
        end
        else if (rows.ready)
        begin
            row_reg <= row_reg + 2'd1;
        end
    end

    // output register: data, zeroed for a degenerate item
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg_reg <= t7_zero_reg;
            for (int i = 0; i < 3; i++)
            begin
                ot_reg[i] <= t7_zero_reg ? '0 : tr_next[i];
                for (int j = 0; j < 3; j++)
                begin
                    om_reg[i][j] <= t7_zero_reg ? '0 : t7_m_reg[i][j];
                end
            end
        end
    end

    // row select
    always_comb
    begin
        case (row_reg)
            2'd0:
            begin
                rows.row_m0    = om_reg[0][0];
                rows.row_m1    = om_reg[0][1];
                rows.row_m2    = om_reg[0][2];
                rows.row_trans = ot_reg[0];
            end
            2'd1:
            begin
                rows.row_m0    = om_reg[1][0];
                rows.row_m1    = om_reg[1][1];
                rows.row_m2    = om_reg[1][2];
                rows.row_trans = ot_reg[1];
            end
            default:
            begin
                rows.row_m0    = om_reg[2][0];
                rows.row_m1    = om_reg[2][1];
                rows.row_m2    = om_reg[2][2];
                rows.row_trans = ot_reg[2];
            end
        endcase
    end

    assign rows.valid      = ser_vld_reg;
    assign rows.row_index  = row_reg;
    assign rows.degenerate = deg_reg;
    assign rows.last_row   = (row_reg == ROW_LAST);

`ifndef SYNTHESIS
    // row counter steps by one on each accepted non-final row
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && rows.ready && row_reg != ROW_LAST |=>
            rows.valid && row_reg == $past(row_reg) + 2'd1)
        else $error("row counter skipped");

    // an item stays until its final row is taken
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && !(rows.ready && row_reg == ROW_LAST) |=> rows.valid)
        else $error("item dropped before final row");

    // degenerate rows carry zeros
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && rows.degenerate |->
            rows.row_m0 == '0 && rows.row_m1 == '0 && rows.row_m2 == '0
            && rows.row_trans == '0)
        else $error("degenerate row not zeroed");
`endif

endmodule

/* bench/look_at_view_transform_unit_tb.sv */
// testbench for the look-at view transform: predicted rows checked against the block
`timescale 1ns / 1ps

module look_at_view_transform_unit_tb;
    import lavt_pkg::*;

    typedef struct {
        logic               action;
        logic signed [31:0] eye[3];
        logic signed [31:0] focus[3];
        logic signed [31:0] up[3];
    } camera_t;

    typedef struct {
        logic [1:0]         idx;
        logic signed [31:0] m0;
        logic signed [31:0] m1;
        logic signed [31:0] m2;
        logic signed [31:0] trans;
        logic               degen;
        logic               last;
    } row_t;

    logic clk;
    logic rst_n;
    lavt_pts_if  pts();
    lavt_rows_if rows();

    look_at_view_transform_unit dut (
        .clk  (clk),
        .rst_n(rst_n),
        .pts  (pts),
        .rows (rows)
    );

    camera_t pending_cams[$];
    row_t    expected_rows[$];
    int      mismatches;
    bit      long_hold;
    int      burst_left;
    int      gap_left;
    longint  cycle_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] clamp_unit(input logic signed [63:0] v);
        if (v > 64'sd1073741824)
        begin
            return 64'sd1073741824;
        end
        if (v < -64'sd1073741824)
        begin
            return -64'sd1073741824;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
                                                      input int s);
        logic [63:0] m;
        m = (mag_of(v) + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    // nearest integer square root
    function automatic logic [63:0] sqrt_nearest(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] n;
        r = 0;
        b = 64'd1 << 62;
        n = s;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s - r * r > r) r = r + 1;
        return r;
    endfunction

    // unit vector in Q2.30, returns 0 for a zero vector
    function automatic bit unit_vector(input logic signed [63:0] v[3],
                                       output logic signed [63:0] u[3]);
        logic [63:0] a[3];
        logic [63:0] mx;
        logic [63:0] s;
        logic [63:0] n;
        logic [63:0] q;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = mag_of(v[i]);
            if (a[i] > mx) mx = a[i];
            u[i] = 0;
        end
        if (mx == 0) return 1'b0;
        while (mx >= (64'd1 << 31))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + a[i] * a[i];
        n = sqrt_nearest(s);
        for (int i = 0; i < 3; i++)
        begin
            q = ((a[i] << 30) + (n >> 1)) / n;
            u[i] = clamp_unit(v[i][63] ? -$signed(q) : $signed(q));
        end
        return 1'b1;
    endfunction

    function automatic void cross_wide(input logic signed [63:0] a[3],
                                       input logic signed [63:0] b[3],
                                       output logic signed [63:0] r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // expected rows of one camera
    function automatic void predict_rows(input camera_t c);
        logic signed [63:0] eye[3];
        logic signed [63:0] up[3];
        logic signed [63:0] zr[3];
        logic signed [63:0] z[3];
        logic signed [63:0] xr[3];
        logic signed [63:0] x[3];
        logic signed [63:0] yr[3];
        logic signed [63:0] y[3];
        logic signed [63:0] m[3][3];
        logic signed [63:0] t[3];
        logic signed [63:0] acc;
        logic signed [63:0] r;
        bit ok;
        row_t row;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = c.eye[i];
            zr[i] = 64'(c.eye[i]) - 64'(c.focus[i]);
            up[i] = c.up[i];
        end
        ok = unit_vector(zr, z);
        if (ok)
        begin
            cross_wide(up, z, xr);
            ok = unit_vector(xr, x);
        end
        for (int i = 0; i < 3; i++)
        begin
            t[i] = 0;
            for (int j = 0; j < 3; j++) m[i][j] = 0;
        end
        if (ok)
        begin
            cross_wide(z, x, yr);
            for (int i = 0; i < 3; i++) y[i] = clamp_unit(round_away(yr[i], 30));
            for (int j = 0; j < 3; j++)
            begin
                if (c.action == ACT_TO_VIEW)
                begin
                    m[0][j] = x[j];
                    m[1][j] = y[j];
                    m[2][j] = z[j];
                end
                else
                begin
                    m[j][0] = x[j];
                    m[j][1] = y[j];
                    m[j][2] = z[j];
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                if (c.action == ACT_TO_VIEW)
                begin
                    acc = 0;
                    for (int j = 0; j < 3; j++) acc = acc + m[i][j] * eye[j];
                    r = round_away(-acc, 30);
                    if (r > 64'sd2147483647) r = 64'sd2147483647;
                    if (r < -64'sd2147483648) r = -64'sd2147483648;
                    t[i] = r;
                end
                else
                begin
                    t[i] = eye[i];
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            row.idx   = 2'(i);
            row.m0    = m[i][0][31:0];
            row.m1    = m[i][1][31:0];
            row.m2    = m[i][2][31:0];
            row.trans = t[i][31:0];
            row.degen = !ok;
            row.last  = (2'(i) == ROW_LAST);
            expected_rows.push_back(row);
        end
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(0, 2000)) - 32'd1000);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic camera_t make_cam(input int act,
                                         input logic signed [31:0] e0, e1, e2,
                                         input logic signed [31:0] f0, f1, f2,
                                         input logic signed [31:0] u0, u1, u2);
        camera_t c;
        c.action = 1'(act);
        c.eye[0] = e0; c.eye[1] = e1; c.eye[2] = e2;
        c.focus[0] = f0; c.focus[1] = f1; c.focus[2] = f2;
        c.up[0] = u0; c.up[1] = u1; c.up[2] = u2;
        return c;
    endfunction

    // random camera: mostly moderate positions, at times extreme words, a unit axis as up in half the cases
    function automatic camera_t random_cam();
        camera_t c;
        int ax;
        c.action = 1'($urandom_range(0, 1));
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                c.eye[i] = rand_word();
                c.focus[i] = rand_word();
                c.up[i] = rand_word();
            end
            else
            begin
                c.eye[i] = $signed($urandom()) >>> $urandom_range(0, 12);
                c.focus[i] = $signed($urandom()) >>> $urandom_range(0, 12);
                c.up[i] = $signed($urandom()) >>> $urandom_range(2, 8);
            end
        end
        ax = $urandom_range(0, 5);
        if (ax < 3)
        begin
            c.up[0] = 0; c.up[1] = 0; c.up[2] = 0;
            c.up[ax] = ($urandom_range(0, 1) != 0) ? ONE_Q30 : -ONE_Q30;
        end
        if ($urandom_range(0, 19) == 0) c.focus = c.eye;
        return c;
    endfunction

    // stimulus
    initial
    begin
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        for (int a = 0; a < 2; a++)
        begin
            // ordinary camera looking down -z
            pending_cams.push_back(make_cam(a, 0, 0, 32'sh5_0000, 0, 0, 0, 0, ONE_Q30, 0));
            // eye equals focus
            pending_cams.push_back(make_cam(a, 32'sh1_0000, 2, 3, 32'sh1_0000, 2, 3,
                                            0, ONE_Q30, 0));
            // up parallel to view direction
            pending_cams.push_back(make_cam(a, 0, 32'sh3_0000, 0, 0, 0, 0, 0, ONE_Q30, 0));
            // zero up
            pending_cams.push_back(make_cam(a, 1, 2, 3, 4, 5, 6, 0, 0, 0));
            // up not of unit length
            pending_cams.push_back(make_cam(a, 7, 0, 0, 0, 0, 0, 0, 0, 32'sh0000_1234));
            // extreme positions, the translation can saturate in mode 0
            pending_cams.push_back(make_cam(a, mx, mx, mx, mn, mn, mn, mn, mx, 0));
            pending_cams.push_back(make_cam(a, mn, mn, mx, mx, mx, mn, mx, mn, mx));
            pending_cams.push_back(make_cam(a, mn, 0, 0, mx, 0, 0, 0, mn, mn));
            pending_cams.push_back(make_cam(a, -1, -1, -1, 0, 0, 0, -1, -1, 0));
            pending_cams.push_back(make_cam(a, mx, mn, 0, mx, mn, 1, mx, mx, mx));
        end
        for (int k = 0; k < 360; k++) pending_cams.push_back(random_cam());
    end

    // input driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts.valid   <= 1'b0;
            pts.action  <= 1'b0;
            pts.eye_x   <= '0;
            pts.eye_y   <= '0;
            pts.eye_z   <= '0;
            pts.focus_x <= '0;
            pts.focus_y <= '0;
            pts.focus_z <= '0;
            pts.up_x    <= '0;
            pts.up_y    <= '0;
            pts.up_z    <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end
        else
        begin
            if (pts.valid && pts.ready)
            begin
                predict_rows(pending_cams.pop_front());
            end
            if (!pts.valid || pts.ready)
            begin
                if (gap_left > 0)
                begin
                    pts.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_cams.size() == 0)
                begin
                    pts.valid <= 1'b0;
                end
                else
                begin
                    pts.valid <= 1'b1;
                    pts.action  <= pending_cams[0].action;
                    pts.eye_x   <= pending_cams[0].eye[0];
                    pts.eye_y   <= pending_cams[0].eye[1];
                    pts.eye_z   <= pending_cams[0].eye[2];
                    pts.focus_x <= pending_cams[0].focus[0];
                    pts.focus_y <= pending_cams[0].focus[1];
                    pts.focus_z <= pending_cams[0].focus[2];
                    pts.up_x    <= pending_cams[0].up[0];
                    pts.up_y    <= pending_cams[0].up[1];
                    pts.up_z    <= pending_cams[0].up[2];
                    if (burst_left > 0)
                    begin
                        burst_left <= burst_left - 1;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(0, 20);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // one long hold-off of the receiver while inputs keep coming
    initial
    begin
        long_hold = 1'b0;
        wait (rst_n);
        repeat (400) @(posedge clk);
        long_hold <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold <= 1'b0;
    end

    // receiver stall pattern and result checks
    always @(posedge clk or negedge rst_n)
    begin
        row_t e;
        if (!rst_n)
        begin
            rows.ready <= 1'b0;
            mismatches <= 0;
        end
        else
        begin
            if (long_hold)
            begin
                rows.ready <= 1'b0;
            end
            else if (cycle_count[10:9] == 2'd0)
            begin
                rows.ready <= 1'b1;
            end
            else
            begin
                rows.ready <= ($urandom_range(0, 3) != 0);
            end
            if (rows.valid && rows.ready)
            begin
                if (expected_rows.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected row transaction, row %0d", rows.row_index);
                end
                else
                begin
                    e = expected_rows.pop_front();
                    if (rows.row_index !== e.idx || rows.row_m0 !== e.m0 ||
                        rows.row_m1 !== e.m1 || rows.row_m2 !== e.m2 ||
                        rows.row_trans !== e.trans || rows.degenerate !== e.degen ||
                        rows.last_row !== e.last)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $display("row mismatch exp: %0d %h %h %h %h deg %b last %b",
                                     e.idx, e.m0, e.m1, e.m2, e.trans, e.degen, e.last);
                            $display("             got: %0d %h %h %h %h deg %b last %b",
                                     rows.row_index, rows.row_m0, rows.row_m1,
                                     rows.row_m2, rows.row_trans, rows.degenerate,
                                     rows.last_row);
                        end
                    end
                end
            end
        end
    end

    // reset, cycle limit and end of run
    initial
    begin
        rst_n = 1'b0;
        cycle_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while ((pending_cams.size() != 0 || pts.valid || expected_rows.size() != 0)
               && cycle_count < 200000)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        if (cycle_count >= 200000)
        begin
            $display("** look_at_view_transform_unit: FAILED **");
        end
        else
        begin
            repeat (300) @(posedge clk);
            if (mismatches == 0 && expected_rows.size() == 0)
            begin
                $display("** look_at_view_transform_unit: PASSED **");
            end
            else
            begin
                $display("** look_at_view_transform_unit: FAILED **");
            end
        end
        $finish;
    end
endmodule
